FILE: hw/rtl/strb_pkg.sv
// Package for the sequenced trace ring buffer: sizes, mode codes, shared types.
// No dependencies.
`default_nettype none
package strb_pkg;
  localparam int unsigned RingDepth = 32;
  localparam int unsigned SlotW = $clog2(RingDepth);
  localparam int unsigned CntW = $clog2(RingDepth + 1);
  localparam int unsigned QDepth = 2;

  typedef enum logic [2:0] {
    MODE_RECORD = 3'd0,
    MODE_START  = 3'd1,
    MODE_STOP   = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_READ   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_START = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // One classified command from the front end.
  typedef struct packed {
    op_e          op;
    logic         stop;
    logic [7:0]   tag;
    logic [63:0]  dur;
    logic [63:0]  key;
    logic [63:0]  gen;
    logic [63:0]  cause;
    logic [63:0]  aux;
    logic [63:0]  status;
    logic [63:0]  now;
    logic [5:0]   cap;
    logic [5:0]   maxev;
  } cmd_t;

  // Payload of one result item.
  typedef struct packed {
    logic         is_header;
    logic         last;
    logic [63:0]  seq;
    logic [63:0]  elapsed;
    logic [63:0]  dur;
    logic [7:0]   tag;
    logic [63:0]  key;
    logic [63:0]  gen;
    logic [63:0]  cause;
    logic [63:0]  aux;
    logic [63:0]  status;
  } res_t;
endpackage
`default_nettype wire

FILE: hw/rtl/strb_front.sv
// Front end: classifies each input item against the mirrored enable flag and the
// configured capacity, drops no-ops, and queues commands. Uses strb_pkg.
`default_nettype none
module strb_front
  import strb_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [2:0]   mode_i,
  input  wire logic [4:0]   kind_i,
  input  wire logic [1:0]   role_i,
  input  wire logic         chunk_i,
  input  wire logic [63:0]  key_i,
  input  wire logic [63:0]  gen_i,
  input  wire logic [63:0]  cause_i,
  input  wire logic [63:0]  aux_i,
  input  wire logic [63:0]  dur_i,
  input  wire logic [63:0]  status_i,
  input  wire logic [63:0]  now_i,
  input  wire logic [5:0]   maxev_i,
  input  wire logic [5:0]   cap_i,
  output logic              cmd_valid_o,
  input  wire logic         cmd_ready_i,
  output cmd_t              cmd_o
);
  cmd_t              q_mem [QDepth];
  logic              wp_q, rp_q;
  logic [1:0]        cnt_q;
  logic              en_q, en_d;
  logic              keep;
  cmd_t              c;
  logic              push, pop;

  assign in_ready_o  = (cnt_q != 2'(QDepth));
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rp_q];

  always_comb begin
    c        = '0;
    keep     = 1'b0;
    en_d     = en_q;
    c.now    = now_i;
    c.cap    = cap_i;
    c.maxev  = maxev_i;
    c.cause  = cause_i;
    if (mode_i == MODE_RECORD) begin
      keep   = en_q;
      c.op   = OP_PUSH;
      c.tag  = {chunk_i, kind_i, role_i};
      c.dur  = dur_i;
      c.key  = chunk_i ? key_i : 64'd0;
      c.gen  = gen_i;
      c.aux  = aux_i;
      c.status = status_i;
    end else if (mode_i == MODE_START) begin
      keep = (cap_i != 6'd0) && (cap_i <= 6'(RingDepth));
      c.op = OP_START;
      if (keep) en_d = 1'b1;
    end else if (mode_i == MODE_STOP) begin
      // enable is only ever set by a valid start, so capacity is nonzero here
      keep   = en_q;
      c.op   = OP_PUSH;
      c.stop = 1'b1;
      c.tag  = 8'd4;
      c.cause = 64'd0;
      en_d   = 1'b0;
    end else if (mode_i == MODE_CLEAR) begin
      keep = 1'b1;
      c.op = OP_CLEAR;
    end else if (mode_i == MODE_READ) begin
      keep = 1'b1;
      c.op = OP_READ;
    end
  end

  assign push = in_valid_i && in_ready_o && keep;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
      en_q  <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) en_q <= en_d;
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/strb_back.sv
// Back end: owns the ring memory and counters, executes commands and streams
// read results through an output register. Uses strb_pkg.
`default_nettype none
module strb_back
  import strb_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  output logic       res_valid_o,
  input  wire logic  res_ready_i,
  output res_t       res_o
);
  typedef struct packed {
    logic [63:0] elapsed;
    logic [63:0] dur;
    logic [7:0]  tag;
    logic [63:0] key;
    logic [63:0] gen;
    logic [63:0] cause;
    logic [63:0] aux;
    logic [63:0] status;
  } ent_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_HDR  = 3'b010,
    ST_EVT  = 3'b100
  } st_e;

  ent_t            mem [RingDepth];
  ent_t            rd_q;
  ent_t            ev_q;
  st_e             st_q;
  logic [SlotW-1:0] wslot_q;
  logic [CntW-1:0] ret_q, cap_q;
  logic [63:0]     nseq_q, drop_q, epoch_q;
  logic            en_q;
  // read walk
  logic [63:0]     seq_q;
  logic [CntW-1:0] left_q;
  logic [SlotW-1:0] rslot_q;
  logic            ov_full_q, ov_hdr_q, ov_last_q;
  logic [63:0]     ov_seq_q;
  res_t            hdr_q;

  logic            take, out_free, adv, load_out;
  logic [63:0]     first_ret, start, avail;
  logic [CntW-1:0] cnt, oldest_c;
  logic [6:0]      tmp;
  logic [SlotW-1:0] slot_nx;
  logic            wr;
  ent_t            wdat;
  logic [CntW-1:0] wcap;
  logic [SlotW-1:0] wat, rslot_inc, rd_addr;

  assign out_free    = !ov_full_q || res_ready_i;
  // hold new commands while a header-only read still waits in the output register
  assign cmd_ready_o = (st_q == ST_IDLE) && !(ov_full_q && ov_hdr_q);
  assign take        = cmd_valid_i && cmd_ready_o;
  assign first_ret   = nseq_q - 64'(ret_q);
  assign adv         = (st_q == ST_EVT) && out_free && left_q != '0;
  assign load_out    = ((st_q == ST_HDR) && out_free) || adv;

  always_comb begin
    start = (cmd_i.cause > first_ret) ? cmd_i.cause : first_ret;
    if (start > nseq_q) start = nseq_q;
    avail = nseq_q - start;
    cnt = (avail < 64'(cmd_i.maxev)) ? CntW'(avail) : CntW'(cmd_i.maxev);
    if (cnt > ret_q) cnt = ret_q;
    if (cap_q == '0 || ret_q == '0 || cmd_i.maxev == 6'd0) cnt = '0;
    // oldest slot, then plus offset of start, each sum wrapped once
    tmp = 7'(wslot_q) + 7'(cap_q) - 7'(ret_q);
    if (tmp >= 7'(cap_q)) tmp = tmp - 7'(cap_q);
    oldest_c = CntW'(tmp);
    tmp = 7'(oldest_c) + 7'(start - first_ret);
    if (tmp >= 7'(cap_q)) tmp = tmp - 7'(cap_q);
    slot_nx = SlotW'(tmp);
  end

  // write path
  always_comb begin
    wdat = '0;
    wr   = 1'b0;
    wcap = cap_q;
    if (take && cmd_i.op == OP_PUSH) begin
      wr           = 1'b1;
      wdat.elapsed = cmd_i.now - epoch_q;
      wdat.dur     = cmd_i.dur;
      wdat.tag     = cmd_i.tag;
      wdat.key     = cmd_i.key;
      wdat.gen     = cmd_i.gen;
      wdat.cause   = cmd_i.cause;
      wdat.aux     = cmd_i.aux;
      wdat.status  = cmd_i.status;
    end else if (take && cmd_i.op == OP_START) begin
      wr   = 1'b1;
      wcap = CntW'(cmd_i.cap);
    end
  end

  assign wat = (take && cmd_i.op == OP_START) ? '0 : wslot_q;

  // read one slot ahead on advance so rd_q holds the entry at rslot_q in ST_EVT
  assign rslot_inc = (CntW'(rslot_q) + CntW'(1) >= cap_q) ? '0 : rslot_q + SlotW'(1);
  assign rd_addr   = adv ? rslot_inc : rslot_q;

  always_ff @(posedge clk_i) begin
    if (wr) mem[wat] <= wdat;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      wslot_q   <= '0;
      ret_q     <= '0;
      cap_q     <= '0;
      nseq_q    <= '0;
      drop_q    <= '0;
      epoch_q   <= '0;
      ov_full_q <= 1'b0;
      ov_hdr_q  <= 1'b0;
      ov_last_q <= 1'b0;
      ov_seq_q  <= '0;
      hdr_q     <= '0;
      seq_q     <= '0;
      rslot_q   <= '0;
      left_q    <= '0;
    end else begin
      if (load_out) ov_full_q <= 1'b1;
      else if (res_ready_i) ov_full_q <= 1'b0;
      if (wr) begin
        if (take && cmd_i.op == OP_START) begin
          cap_q   <= wcap;
          epoch_q <= cmd_i.now;
          nseq_q  <= 64'd1;
          drop_q  <= '0;
          ret_q   <= CntW'(1);
          wslot_q <= (wcap == CntW'(1)) ? '0 : SlotW'(1);
        end else begin
          wslot_q <= (CntW'(wslot_q) + CntW'(1) >= cap_q) ? '0 : wslot_q + SlotW'(1);
          nseq_q  <= nseq_q + 64'd1;
          if (ret_q < cap_q) ret_q <= ret_q + CntW'(1);
          else drop_q <= drop_q + 64'd1;
        end
      end
      if (take && cmd_i.op == OP_CLEAR) begin
        wslot_q <= '0;
        ret_q   <= '0;
        nseq_q  <= '0;
        drop_q  <= '0;
        epoch_q <= cmd_i.now;
      end
      unique case (st_q)
        ST_IDLE: begin
          if (take && cmd_i.op == OP_READ) begin
            hdr_q.is_header <= 1'b1;
            hdr_q.last      <= (cnt == '0);
            hdr_q.seq       <= nseq_q;
            hdr_q.elapsed   <= first_ret;
            hdr_q.dur       <= drop_q;
            hdr_q.tag       <= {7'd0, en_q};
            hdr_q.key       <= 64'(ret_q);
            hdr_q.gen       <= '0;
            hdr_q.cause     <= 64'(cap_q);
            hdr_q.aux       <= '0;
            hdr_q.status    <= '0;
            seq_q   <= start;
            left_q  <= cnt;
            rslot_q <= slot_nx;
            st_q    <= ST_HDR;
          end
        end
        ST_HDR: begin
          if (out_free) begin
            ov_hdr_q  <= 1'b1;
            st_q      <= (left_q == '0) ? ST_IDLE : ST_EVT;
          end
        end
        ST_EVT: begin
          // rd_q holds the entry at rslot_q
          if (adv) begin
            ov_hdr_q  <= 1'b0;
            ov_last_q <= (left_q == CntW'(1));
            ov_seq_q  <= seq_q;
            seq_q     <= seq_q + 64'd1;
            left_q    <= left_q - CntW'(1);
            rslot_q   <= rslot_inc;
            if (left_q == CntW'(1)) st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // enable flag mirror for the header
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) en_q <= 1'b0;
    else if (take && cmd_i.op == OP_START) en_q <= 1'b1;
    else if (take && cmd_i.op == OP_PUSH && cmd_i.stop) en_q <= 1'b0;
  end

  // event payload captured at the moment of advance
  always_ff @(posedge clk_i) begin
    if (adv) ev_q <= rd_q;
  end

  assign res_valid_o = ov_full_q;
  always_comb begin
    if (ov_hdr_q) begin
      res_o = hdr_q;
    end else begin
      res_o.is_header = 1'b0;
      res_o.last      = ov_last_q;
      res_o.seq       = ov_seq_q;
      res_o.elapsed   = ev_q.elapsed;
      res_o.dur       = ev_q.dur;
      res_o.tag       = ev_q.tag;
      res_o.key       = ev_q.key;
      res_o.gen       = ev_q.gen;
      res_o.cause     = ev_q.cause;
      res_o.aux       = ev_q.aux;
      res_o.status    = ev_q.status;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/sequenced_trace_ring_buffer_unit.sv
// Top level of the sequenced trace ring buffer: front end, command queue, back end.
// Depends on strb_pkg, strb_front, strb_back.
`default_nettype none
// Overwriting event trace ring of up to 32 slots. An accepted input transfer that
// is kept lands in a two-entry command queue for the back end; modes 5 to 7, start
// with a capacity of 0 or above 32, and record or stop with recording off are
// dropped at the input. A read registers its header, loads it into the output
// register from the header state, then sends one retained event per cycle while
// the output register is free. A waiting result stalls the back end, then the queue,
// then s_axis_tready; a header-only read also holds the next command until its
// header is taken. Capacity is written through cfg_we_i and is latched when a
// start transfer is accepted.
module sequenced_trace_ring_buffer_unit
  import strb_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [5:0]    cfg_wdata_i,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // mode, event kind, thread role, chunk flag, chunk key, generation,
  // cause or first sequence, auxiliary, duration, status, now, max events
  input  wire logic [471:0]  s_axis_tdata,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // sequence, elapsed, out_duration, event_tag, out_key,
  // out_generation, out_cause, out_auxiliary, out_status
  output logic [519:0]       m_axis_tdata,
  output logic               m_axis_tlast,
  output logic               m_axis_tuser   // is_header
);
  logic [5:0] cap_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= 6'd32;
    else if (cfg_we_i) cap_q <= cfg_wdata_i;
  end

  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;

  strb_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (s_axis_tdata[2:0]),
    .kind_i     (s_axis_tdata[7:3]),
    .role_i     (s_axis_tdata[9:8]),
    .chunk_i    (s_axis_tdata[10]),
    .key_i      (s_axis_tdata[74:11]),
    .gen_i      (s_axis_tdata[138:75]),
    .cause_i    (s_axis_tdata[202:139]),
    .aux_i      (s_axis_tdata[266:203]),
    .dur_i      (s_axis_tdata[330:267]),
    .status_i   (s_axis_tdata[394:331]),
    .now_i      (s_axis_tdata[458:395]),
    .maxev_i    (s_axis_tdata[464:459]),
    .cap_i      (cap_q),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  strb_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tlast = res.last;
  assign m_axis_tuser = res.is_header;
  assign m_axis_tdata = {res.status, res.aux, res.cause, res.gen, res.key,
                         res.tag, res.dur, res.elapsed, res.seq};
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for sequenced_trace_ring_buffer_unit.
// Drives trace commands over the input stream and checks the read streams against a
// built-in model of the ring. Depends on strb_pkg and the RTL top level.
`timescale 1ns / 1ps
module testbench;
  import strb_pkg::*;

  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int unsigned DrainWait = 20;
  localparam int unsigned StallLimit = 3000;

  typedef struct {
    logic [2:0]  mode;
    logic [4:0]  kind;
    logic [1:0]  role;
    logic        chunk;
    logic [63:0] key;
    logic [63:0] gen;
    logic [63:0] cause;
    logic [63:0] aux;
    logic [63:0] dur;
    logic [63:0] status;
    logic [63:0] now;
    logic [5:0]  maxev;
  } trace_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [5:0] cfg_wdata_i = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [471:0] in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [519:0] out_word;
  logic out_last;
  logic out_header;

  always #10 clk_i = ~clk_i;

  sequenced_trace_ring_buffer_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(in_valid),
    .s_axis_tready(in_ready),
    .s_axis_tdata (in_word),
    .m_axis_tvalid(out_valid),
    .m_axis_tready(out_ready),
    .m_axis_tdata (out_word),
    .m_axis_tlast (out_last),
    .m_axis_tuser (out_header)
  );

  // Ring model state
  logic [63:0] el_mem [RingDepth];
  logic [63:0] dur_mem [RingDepth];
  logic [7:0]  tag_mem [RingDepth];
  logic [63:0] key_mem [RingDepth];
  logic [63:0] gen_mem [RingDepth];
  logic [63:0] cause_mem [RingDepth];
  logic [63:0] aux_mem [RingDepth];
  logic [63:0] stat_mem [RingDepth];
  int unsigned wr_slot = 0, held = 0, cap_used = 0;
  logic [63:0] seq_next = '0, drop_cnt = '0, epoch = '0;
  bit rec_on = 1'b0;
  logic [5:0] cap_cfg = 6'd32;

  trace_cmd_t pending_cmds[$];
  trace_cmd_t cur_cmd;
  res_t trace_expect[$];
  bit failed = 1'b0;
  int unsigned cyc = 0;
  int unsigned quiet_cnt = 0;
  int unsigned hold_cnt = 0;
  bit hold_done = 1'b0;
  logic [63:0] clock_ns = 64'd1000;
  logic [63:0] approx_seq = '0;

  function automatic logic [471:0] pack_cmd(trace_cmd_t c);
    return {7'd0, c.maxev, c.now, c.status, c.dur, c.aux, c.cause, c.gen, c.key,
            c.chunk, c.role, c.kind, c.mode};
  endfunction

  function automatic void store_event(logic [7:0] tag, logic [63:0] el, logic [63:0] d,
                                      logic [63:0] k, logic [63:0] g, logic [63:0] c,
                                      logic [63:0] a, logic [63:0] s);
    if (cap_used == 0) return;
    el_mem[wr_slot] = el;
    dur_mem[wr_slot] = d;
    tag_mem[wr_slot] = tag;
    key_mem[wr_slot] = k;
    gen_mem[wr_slot] = g;
    cause_mem[wr_slot] = c;
    aux_mem[wr_slot] = a;
    stat_mem[wr_slot] = s;
    wr_slot = (wr_slot + 1) % cap_used;
    seq_next++;
    if (held < cap_used) held++;
    else drop_cnt++;
  endfunction

  function automatic void trace_apply(trace_cmd_t c);
    logic [63:0] first_ret, start, avail, cnt;
    int unsigned oldest, slot;
    res_t r;
    first_ret = '0; start = '0; avail = '0; cnt = '0; oldest = 0; slot = 0;
    case (c.mode)
      MODE_RECORD: begin
        if (rec_on)
          store_event({c.chunk, c.kind, c.role}, c.now - epoch, c.dur,
                      c.chunk ? c.key : 64'd0, c.gen, c.cause, c.aux, c.status);
      end
      MODE_START: begin
        if (cap_cfg != 0 && cap_cfg <= RingDepth) begin
          cap_used = cap_cfg;
          wr_slot = 0; held = 0; seq_next = '0; drop_cnt = '0;
          epoch = c.now;
          store_event(8'd0, '0, '0, '0, '0, '0, '0, '0);
          rec_on = 1'b1;
        end
      end
      MODE_STOP: begin
        if (rec_on && cap_used != 0) begin
          store_event(8'd4, c.now - epoch, '0, '0, '0, '0, '0, '0);
          rec_on = 1'b0;
        end
      end
      MODE_CLEAR: begin
        wr_slot = 0; held = 0; seq_next = '0; drop_cnt = '0;
        epoch = c.now;
      end
      MODE_READ: begin
        first_ret = seq_next - 64'(held);
        if (cap_used != 0 && held != 0 && c.maxev != 0) begin
          start = (c.cause > first_ret) ? c.cause : first_ret;
          if (start > seq_next) start = seq_next;
          avail = seq_next - start;
          cnt = (avail < 64'(c.maxev)) ? avail : 64'(c.maxev);
          if (cnt > 64'(held)) cnt = 64'(held);
          oldest = (wr_slot + cap_used - held) % cap_used;
        end
        r = '0;
        r.is_header = 1'b1;
        r.last = (cnt == 0);
        r.seq = seq_next;
        r.elapsed = first_ret;
        r.dur = drop_cnt;
        r.tag = {7'd0, rec_on};
        r.key = 64'(held);
        r.cause = 64'(cap_used);
        trace_expect.insert(trace_expect.size(), r);
        for (logic [63:0] i = 0; i < cnt; i++) begin
          slot = 32'((64'(oldest) + (start + i - first_ret)) % 64'(cap_used));
          r.is_header = 1'b0;
          r.last = (i + 1 == cnt);
          r.seq = start + i;
          r.elapsed = el_mem[slot];
          r.dur = dur_mem[slot];
          r.tag = tag_mem[slot];
          r.key = key_mem[slot];
          r.gen = gen_mem[slot];
          r.cause = cause_mem[slot];
          r.aux = aux_mem[slot];
          r.status = stat_mem[slot];
          trace_expect.insert(trace_expect.size(), r);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      failed = 1'b1;
    end
  endfunction

  // Driver: advance on transfer, idle at random outside the quiet window
  always @(posedge clk_i) begin
    bit idle_now;
    cyc <= cyc + 1;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        trace_apply(cur_cmd);
        quiet_cnt = 0;
      end
      if (!in_valid || in_ready) begin
        idle_now = (cyc < 800 || cyc > 1600) && ($urandom_range(99) < 7);
        if (pending_cmds.size() != 0 && !idle_now) begin
          cur_cmd = pending_cmds.pop_front();
          in_word <= pack_cmd(cur_cmd);
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    res_t act, exp_r;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        quiet_cnt = 0;
        act.is_header = out_header;
        act.last = out_last;
        act.seq = out_word[63:0];
        act.elapsed = out_word[127:64];
        act.dur = out_word[191:128];
        act.tag = out_word[199:192];
        act.key = out_word[263:200];
        act.gen = out_word[327:264];
        act.cause = out_word[391:328];
        act.aux = out_word[455:392];
        act.status = out_word[519:456];
        if (trace_expect.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, out_word);
          failed = 1'b1;
        end else begin
          exp_r = trace_expect.pop_front();
          check_field("is_header", exp_r.is_header, act.is_header);
          check_field("last", exp_r.last, act.last);
          check_field("sequence", exp_r.seq, act.seq);
          check_field("elapsed", exp_r.elapsed, act.elapsed);
          check_field("duration", exp_r.dur, act.dur);
          check_field("tag", exp_r.tag, act.tag);
          check_field("key", exp_r.key, act.key);
          check_field("generation", exp_r.gen, act.gen);
          check_field("cause", exp_r.cause, act.cause);
          check_field("auxiliary", exp_r.aux, act.aux);
          check_field("status", exp_r.status, act.status);
        end
      end
      // hold off once for a long stretch so the input backs up
      if (!hold_done && cyc >= 300 && pending_cmds.size() > 20) begin
        hold_cnt <= 400;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !((cyc < 800 || cyc > 1600) && ($urandom_range(99) < 7));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cnt = quiet_cnt + 1;
      if (quiet_cnt > StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic trace_cmd_t make_cmd(logic [2:0] mode);
    trace_cmd_t c;
    c.mode = mode;
    c.kind = 5'($urandom_range(31));
    c.role = 2'($urandom_range(3));
    c.chunk = 1'($urandom_range(1));
    c.key = rnd64();
    c.gen = rnd64();
    c.cause = rnd64();
    c.aux = rnd64();
    c.dur = rnd64();
    c.status = rnd64();
    if ($urandom_range(49) == 0) clock_ns = rnd64();
    else clock_ns = clock_ns + $urandom_range(500);
    c.now = clock_ns;
    c.maxev = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(32));
    return c;
  endfunction

  task automatic add_cmd(trace_cmd_t c);
    if (c.mode == MODE_RECORD || c.mode == MODE_START || c.mode == MODE_STOP)
      approx_seq = approx_seq + 1;
    if (c.mode == MODE_READ) begin
      case ($urandom_range(9))
        0: c.cause = rnd64();
        1: c.cause = '0;
        default: c.cause = approx_seq - $urandom_range(40);
      endcase
    end
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || in_valid || trace_expect.size() != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [5:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    cap_cfg = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    trace_cmd_t c;
    int unsigned r;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // before any start: read, record and stop do nothing to the ring
    add_cmd(make_cmd(MODE_READ));
    add_cmd(make_cmd(MODE_RECORD));
    add_cmd(make_cmd(MODE_STOP));
    settle();
    write_capacity(6'd0);
    add_cmd(make_cmd(MODE_START));
    add_cmd(make_cmd(MODE_READ));
    settle();
    write_capacity(6'd33);
    add_cmd(make_cmd(MODE_START));
    add_cmd(make_cmd(MODE_READ));
    settle();
    write_capacity(6'd1);
    add_cmd(make_cmd(MODE_START));
    c = make_cmd(MODE_RECORD);
    c.kind = 5'd31; c.role = 2'd3; c.chunk = 1'b1; c.key = '1; c.gen = '1;
    c.cause = '1; c.aux = '1; c.dur = '1; c.status = 64'h8000_0000_0000_0000;
    c.now = '0;
    add_cmd(c);
    c = make_cmd(MODE_RECORD);
    c.kind = '0; c.role = '0; c.chunk = 1'b0; c.status = 64'h7fff_ffff_ffff_ffff;
    add_cmd(c);
    c = make_cmd(MODE_READ); c.maxev = 6'd32; c.cause = '0;
    pending_cmds.insert(pending_cmds.size(), c);
    settle();
    write_capacity(6'd32);
    c = make_cmd(MODE_START); c.now = '1;
    add_cmd(c);
    c = make_cmd(MODE_RECORD); c.now = 64'd5;
    add_cmd(c);
    add_cmd(make_cmd(MODE_STOP));
    add_cmd(make_cmd(MODE_STOP));
    add_cmd(make_cmd(MODE_RECORD));
    c = make_cmd(MODE_READ); c.maxev = 6'd0;
    add_cmd(c);
    c = make_cmd(MODE_READ); c.maxev = 6'd63; c.cause = '1;
    pending_cmds.insert(pending_cmds.size(), c);
    add_cmd(make_cmd(MODE_CLEAR));
    add_cmd(make_cmd(MODE_READ));
    add_cmd(make_cmd(MODE_SPARE5));
    add_cmd(make_cmd(MODE_SPARE6));
    add_cmd(make_cmd(MODE_SPARE7));
    add_cmd(make_cmd(MODE_READ));
    settle();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_capacity(6'd1);
        1: write_capacity(6'd32);
        2: write_capacity(6'd2);
        5: write_capacity(6'($urandom_range(63)));
        default: write_capacity(6'($urandom_range(1, 32)));
      endcase
      approx_seq = '0;
      add_cmd(make_cmd(MODE_START));
      for (int n = 0; n < 55; n++) begin
        r = $urandom_range(99);
        if (r < 60) add_cmd(make_cmd(MODE_RECORD));
        else if (r < 78) add_cmd(make_cmd(MODE_READ));
        else if (r < 83) add_cmd(make_cmd(MODE_STOP));
        else if (r < 89) begin
          approx_seq = '0;
          add_cmd(make_cmd(MODE_START));
        end else if (r < 93) begin
          approx_seq = '0;
          add_cmd(make_cmd(MODE_CLEAR));
        end else if (r < 96) add_cmd(make_cmd(3'($urandom_range(5, 7))));
        else add_cmd(make_cmd(MODE_READ));
      end
      add_cmd(make_cmd(MODE_READ));
      settle();
    end

    repeat (50) @(posedge clk_i);
    if (!failed && trace_expect.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/strb_pkg.sv
hw/rtl/strb_front.sv
hw/rtl/strb_back.sv
hw/rtl/sequenced_trace_ring_buffer_unit.sv
tb/testbench.sv
